[sv/sem_pkg.sv]
package sem_pkg;

   // Largest maximum of two constants, for widths of the counter compares
   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Frame limits
   localparam int MAX_LINE_WIDTH   = 512;
   localparam int MAX_FRAME_HEIGHT = 512;

   // Field widths
   localparam int CFG_W  = 10;
   localparam int PIX_W  = 8;
   localparam int GRAD_W = 11;

   // Counter widths: the input row runs up to the frame height plus one
   localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
   localparam int OROW_W = $clog2(MAX_FRAME_HEIGHT);
   localparam int IROW_W = $clog2(MAX_FRAME_HEIGHT + 2);
   localparam int CMP_W  = max_int(max_int(CFG_W, COL_W), IROW_W) + 1;

   // Reset geometry
   localparam int RESET_WIDTH  = 320;
   localparam int RESET_HEIGHT = 240;

   // Luma weights in thousandths, and the reciprocal of 1000 used for the divide
   localparam int LUMA_R      = 299;
   localparam int LUMA_G      = 587;
   localparam int LUMA_B      = 114;
   localparam int SUM_W       = 18;
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + 999) / 1000;

   // Square root: radicand is gx^2 + gy^2 (below 2^21), root fits in 11 bits
   localparam int SQ_W   = 21;
   localparam int ROOT_W = 11;

   localparam int PIX_MAX = 255;

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_GRAY = 7'b0000010,
      S_WIN  = 7'b0000100,
      S_GRAD = 7'b0001000,
      S_SQR  = 7'b0010000,
      S_SQRT = 7'b0100000,
      S_OUT  = 7'b1000000
   } sem_state_type;

   // A dimension of zero acts as one, anything above the limit as the limit
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input int maxv);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (32'(v) > maxv) begin
         r = CFG_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[sv/sem_isqrt.sv]
// Integer square root, two radicand bits per cycle
module sem_isqrt import sem_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] acc_ff, acc_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W-1:0] trial;

   assign trial = acc_ff + bit_ff;

   // One restoring step per cycle, from the top bit pair down
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         acc_in  = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 1);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            acc_in = (acc_ff >> 1) + bit_ff;
         end else begin
            acc_in = acc_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = acc_ff[ROOT_W-1:0];

endmodule

[sv/sobel_edge_magnitude_stream_unit.sv]
// Channel   Handshake             Payload
// req_      req_valid/req_stall   kind, red, green, blue
// rsp_      rsp_valid/rsp_stall   edge_magnitude, grad_x, grad_y, center_gray, last_of_frame
// csr_      csr_valid/csr_ready   index (0 frame_width, 1 frame_height), wdata
//
// An item without a result passes through transfer with line store read, gray divide,
// window update and line store write-back. A flush with no frame open is dropped in its
// transfer cycle. An item with a result goes on through gradients, squares, the 11 steps
// of the square root unit and the output load. One item is in work at a time.
// Reset restores 320x240 and clears counters and window; line stores are not cleared.
// A finished result waits in the output register while the next item is taken; the
// sequencer only stalls when a second result is ready and the first is still stalled.
module sobel_edge_magnitude_stream_unit import sem_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic [PIX_W-1:0]         req_red,
   input  logic [PIX_W-1:0]         req_green,
   input  logic [PIX_W-1:0]         req_blue,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PIX_W-1:0]         rsp_edge_magnitude,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic [PIX_W-1:0]         rsp_center_gray,
   output logic                     rsp_last_of_frame,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [0:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   // Line stores
   logic [PIX_W-1:0] upper_mem [MAX_LINE_WIDTH];
   logic [PIX_W-1:0] lower_mem [MAX_LINE_WIDTH];

   sem_state_type state_ff, state_in;

   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [IROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;
   logic [PIX_W-1:0]  win_ff [9];
   logic [PIX_W-1:0]  win_in [9];

   logic                     kind_ff, kind_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [PIX_W-1:0]         gray_ff, gray_in;
   logic [PIX_W-1:0]         top_rd_ff, mid_rd_ff;
   logic signed [GRAD_W-1:0] gx_ff, gx_in;
   logic signed [GRAD_W-1:0] gy_ff, gy_in;
   logic [PIX_W-1:0]         center_ff, center_in;
   logic                     last_ff, last_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]         rsp_mag_ff;
   logic signed [GRAD_W-1:0] rsp_gx_ff, rsp_gy_ff;
   logic [PIX_W-1:0]         rsp_center_ff;
   logic                     rsp_last_ff;

   logic                       idle, csr_write, req_accept, flush_idle;
   logic [COL_W-1:0]           rd_col;
   logic [SUM_W+RECIP_W-1:0]   gray_prod;
   logic                       col_wrap, emit, ocol_end, orow_end;
   logic                       top_z, bot_z, left_z, right_z;
   logic signed [GRAD_W-1:0]   px [3][3];
   logic signed [GRAD_W-1:0]   gx_val, gy_val;
   logic signed [2*GRAD_W-1:0] sqx, sqy;
   logic [2*GRAD_W-1:0]        sq_sum;
   logic                       sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]          sqrt_root;
   logic [PIX_W-1:0]           mag;
   logic                       out_load;

   // Handshakes: the sequencer takes one item or one register write while idle
   assign idle       = (state_ff == S_IDLE);
   assign csr_ready  = idle;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = !idle || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign flush_idle = req_kind && (in_col_ff == '0) && (in_row_ff == '0);

   // Column of the line stores for this item
   assign rd_col = (CMP_W'(in_col_ff) >= CMP_W'(width_ff)) ? '0 : in_col_ff;

   // Gray divide by 1000 through the reciprocal
   assign gray_prod = (SUM_W+RECIP_W)'(sum_ff) * (SUM_W+RECIP_W)'(RECIP);

   // Raster position of the input and output sides
   assign col_wrap = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(width_ff);
   assign emit     = (in_row_ff >= IROW_W'(2)) || ((in_row_ff == IROW_W'(1)) && (col_ff != '0));
   assign ocol_end = (CMP_W'(out_col_ff) + CMP_W'(1)) >= CMP_W'(width_ff);
   assign orow_end = (CMP_W'(out_row_ff) + CMP_W'(1)) >= CMP_W'(height_ff);

   // Border masking of the window
   assign top_z   = (out_row_ff == '0);
   assign bot_z   = orow_end;
   assign left_z  = (out_col_ff == '0);
   assign right_z = ocol_end;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && top_z) || (r == 2 && bot_z) ||
                (c == 0 && left_z) || (c == 2 && right_z)) begin
               px[r][c] = '0;
            end else begin
               px[r][c] = signed'(GRAD_W'(win_ff[r*3+c]));
            end
         end
      end
   end

   // Sobel responses
   assign gx_val = px[0][2] - px[0][0] + ((px[1][2] - px[1][0]) <<< 1) + px[2][2] - px[2][0];
   assign gy_val = px[0][0] + (px[0][1] <<< 1) + px[0][2]
                 - px[2][0] - (px[2][1] <<< 1) - px[2][2];

   // Sum of squares straight into the root unit
   assign sqx        = gx_ff * gx_ff;
   assign sqy        = gy_ff * gy_ff;
   assign sq_sum     = unsigned'(sqx) + unsigned'(sqy);
   assign sqrt_start = (state_ff == S_SQR);

   sem_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_sum[SQ_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign mag = (sqrt_root > ROOT_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : sqrt_root[PIX_W-1:0];

   // Output register frees the sequencer from the result side
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win_in     = win_ff;
      kind_in    = kind_ff;
      sum_in     = sum_ff;
      col_in     = col_ff;
      gray_in    = gray_ff;
      gx_in      = gx_ff;
      gy_in      = gy_ff;
      center_in  = center_ff;
      last_in    = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_write) begin
               unique case (csr_index_type'(csr_index))
                  CSR_FRAME_WIDTH:  width_in  = clamp_dim(csr_wdata, MAX_LINE_WIDTH);
                  CSR_FRAME_HEIGHT: height_in = clamp_dim(csr_wdata, MAX_FRAME_HEIGHT);
               endcase
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               for (int i = 0; i < 9; i++) begin
                  win_in[i] = '0;
               end
            end else if (req_accept && !flush_idle) begin
               kind_in  = req_kind;
               sum_in   = SUM_W'(req_red) * SUM_W'(LUMA_R)
                        + SUM_W'(req_green) * SUM_W'(LUMA_G)
                        + SUM_W'(req_blue) * SUM_W'(LUMA_B);
               col_in   = rd_col;
               state_in = S_GRAY;
            end
         end
         S_GRAY: begin
            gray_in  = kind_ff ? '0 : gray_prod[RECIP_SHIFT +: PIX_W];
            state_in = S_WIN;
         end
         S_WIN: begin
            // Shift the window and bring in the new column
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]   = win_ff[r*3+1];
               win_in[r*3+1] = win_ff[r*3+2];
            end
            win_in[2] = top_rd_ff;
            win_in[5] = mid_rd_ff;
            win_in[8] = gray_ff;
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + IROW_W'(1);
            end else begin
               in_col_in = col_ff + COL_W'(1);
            end
            state_in = emit ? S_GRAD : S_IDLE;
         end
         S_GRAD: begin
            gx_in     = gx_val;
            gy_in     = gy_val;
            center_in = win_ff[4];
            last_in   = 1'b0;
            if (ocol_end) begin
               out_col_in = '0;
               if (orow_end) begin
                  last_in = 1'b1;
               end else begin
                  out_row_in = out_row_ff + OROW_W'(1);
               end
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
            // Frame end: start over for the next frame
            if (ocol_end && orow_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               for (int i = 0; i < 9; i++) begin
                  win_in[i] = '0;
               end
            end
            state_in = S_SQR;
         end
         S_SQR: begin
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= CFG_W'(RESET_WIDTH);
         height_ff    <= CFG_W'(RESET_HEIGHT);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      sum_ff    <= sum_in;
      col_ff    <= col_in;
      gray_ff   <= gray_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      center_ff <= center_in;
      last_ff   <= last_in;
      if (out_load) begin
         rsp_mag_ff    <= mag;
         rsp_gx_ff     <= gx_ff;
         rsp_gy_ff     <= gy_ff;
         rsp_center_ff <= center_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   // Line stores: read on the item transfer, write back at window update
   always_ff @(posedge clock) begin
      if (req_accept) begin
         top_rd_ff <= upper_mem[rd_col];
         mid_rd_ff <= lower_mem[rd_col];
      end
      if (state_ff == S_WIN) begin
         upper_mem[col_ff] <= mid_rd_ff;
         lower_mem[col_ff] <= gray_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_magnitude = rsp_mag_ff;
   assign rsp_grad_x         = rsp_gx_ff;
   assign rsp_grad_y         = rsp_gy_ff;
   assign rsp_center_gray    = rsp_center_ff;
   assign rsp_last_of_frame  = rsp_last_ff;

   // Checks
   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_col_ff) < CMP_W'(width_ff))
      else $error("input column beyond line width");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !flush_idle) |=> (state_ff == S_GRAY))
      else $error("accepted item did not start the sequence");

   a_root_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_SQRT))
      else $error("root finished outside its wait state");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |-> ((in_row_ff == '0) && (out_row_ff == '0) && (in_col_ff == '0)))
      else $error("frame end did not restart the counters");

endmodule
